// ===== hw/rtl/btb_pkg.sv =====
// shared types and constants of the branch target buffer predictor
package btb_pkg;

   localparam int ENTRIES_DEF = 512;

   localparam logic [3:0] MISPREDICT_CYCLES_RST = 4'd4;
   localparam logic [3:0] BTB_MISS_CYCLES_RST   = 4'd5;

   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_MISPREDICT_CYCLES = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_BTB_MISS_CYCLES   = 1'b1;

   typedef enum logic [2:0] {
      OUT_NOT_BRANCH = 3'd0,
      OUT_BTB_MISS   = 3'd1,
      OUT_UNCOND_HIT = 3'd2,
      OUT_PREDICT_OK = 3'd3,
      OUT_MISPREDICT = 3'd4
   } outcome_type;

   typedef struct packed {
      outcome_type outcome;
      logic [3:0]  cycles;
      logic        hit;
      logic        miss;
      logic        mispredict;
      logic        write;
   } res_type;

   function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

endpackage

// ===== hw/rtl/btb_table.sv =====
// target buffer memory with one read port, one write port and registered read data
module btb_table
   import btb_pkg::*;
#(
   parameter int ENTRIES = ENTRIES_DEF,
   parameter int WIDTH   = 60
) (
   input  logic                       clock,
   input  logic [$clog2(ENTRIES)-1:0] rd_idx,
   output logic [WIDTH-1:0]           rd_data,
   input  logic                       wr_en,
   input  logic [$clog2(ENTRIES)-1:0] wr_idx,
   input  logic [WIDTH-1:0]           wr_data
);

   logic [WIDTH-1:0] mem [ENTRIES];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
      rd_data_ff <= mem[rd_idx];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/btb_eval.sv =====
// hit check, direction prediction and entry update for one item
module btb_eval
   import btb_pkg::*;
#(
   parameter int TAG_W = 55
) (
   input  logic [TAG_W+3:0] entry,
   input  logic             is_branch,
   input  logic             is_conditional,
   input  logic             taken,
   input  logic [TAG_W-1:0] tag,
   input  logic [3:0]       mispredict_cycles,
   input  logic [3:0]       btb_miss_cycles,
   output res_type          res,
   output logic [TAG_W+3:0] new_entry
);

   logic             e_valid;
   logic [TAG_W-1:0] e_tag;
   logic             e_cond;
   logic [1:0]       e_ctr;
   logic             hit;
   logic             predict_taken;
   logic [1:0]       ctr_next;

   assign e_valid = entry[TAG_W+3];
   assign e_tag   = entry[TAG_W+2:3];
   assign e_cond  = entry[2];
   assign e_ctr   = entry[1:0];

   assign hit           = e_valid && (e_tag == tag);
   assign predict_taken = e_ctr[1];

   always_comb begin
      ctr_next = e_ctr;
      if (taken) begin
         if (e_ctr != 2'd3) begin
            ctr_next = e_ctr + 2'd1;
         end
      end else begin
         if (e_ctr != 2'd0) begin
            ctr_next = e_ctr - 2'd1;
         end
      end
   end

   always_comb begin
      res       = '{outcome: OUT_NOT_BRANCH, cycles: 4'd1, hit: 1'b0, miss: 1'b0,
                    mispredict: 1'b0, write: 1'b0};
      new_entry = entry;
      if (is_branch) begin
         res.write = 1'b1;
         if (hit) begin
            res.hit = 1'b1;
            if (!e_cond) begin
               res.outcome = OUT_UNCOND_HIT;
            end else begin
               new_entry = {1'b1, e_tag, 1'b1, ctr_next};
               if (taken == predict_taken) begin
                  res.outcome = OUT_PREDICT_OK;
               end else begin
                  res.outcome    = OUT_MISPREDICT;
                  res.cycles     = mispredict_cycles;
                  res.mispredict = 1'b1;
               end
            end
         end else begin
            res.outcome = OUT_BTB_MISS;
            res.cycles  = btb_miss_cycles;
            res.miss    = 1'b1;
            new_entry   = {1'b1, tag, is_conditional, 2'b00};
         end
      end
   end

endmodule

// ===== hw/rtl/btb_two_bit_branch_predictor.sv =====
// top level of the branch target buffer predictor with 2-bit counters
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   is_branch, pc, inst_size, is_conditional,
//                                             next_address
//   rsp      out        rsp_valid/rsp_stall   outcome, cycles_added and four totals
//   csr      in         csr_wr_en             csr_index, csr_wdata
//
// one item per cycle unless rsp_stall or the table clear holds it; an item waits in the
// s1 registers and its result is registered in the rsp registers; the rate is set by
// the read-modify-write of the table, with a bypass when back-to-back items share an entry
// after reset req_stall stays high while all ENTRIES entries (512 by default) of
// the table are swept clear
// a result held by rsp_stall holds the item behind it, which holds req_stall
module btb_two_bit_branch_predictor
   import btb_pkg::*;
#(
   parameter int ENTRIES = ENTRIES_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_is_branch,
   input  logic [63:0]          req_pc,
   input  logic [3:0]           req_inst_size,
   input  logic                 req_is_conditional,
   input  logic [63:0]          req_next_address,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [2:0]           rsp_outcome,
   output logic [3:0]           rsp_cycles_added,
   output logic [31:0]          rsp_cycle_total,
   output logic [31:0]          rsp_hit_total,
   output logic [31:0]          rsp_miss_total,
   output logic [31:0]          rsp_mispredict_total,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [3:0]           csr_wdata
);

   localparam int IDX_W = $clog2(ENTRIES);
   localparam int TAG_W = 64 - IDX_W;
   localparam int ENT_W = TAG_W + 4;

   logic [3:0]       mispredict_cycles_ff;
   logic [3:0]       btb_miss_cycles_ff;

   logic             clear_ff;
   logic [IDX_W-1:0] clr_idx_ff;

   logic             s1_valid_ff;
   logic             s1_branch_ff;
   logic             s1_cond_ff;
   logic             s1_taken_ff;
   logic [IDX_W-1:0] s1_idx_ff;
   logic [TAG_W-1:0] s1_tag_ff;

   logic             byp_ff;
   logic [ENT_W-1:0] byp_data_ff;

   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   outcome_type      rsp_outcome_ff;
   logic [3:0]       rsp_cycles_ff;

   logic [31:0]      cycle_count_ff;
   logic [31:0]      hit_count_ff;
   logic [31:0]      miss_count_ff;
   logic [31:0]      mispredict_count_ff;

   logic             accept;
   logic             complete;
   logic [IDX_W-1:0] req_idx;
   logic [TAG_W-1:0] req_tag;
   logic [IDX_W-1:0] rd_idx;
   logic [ENT_W-1:0] rd_data;
   logic [ENT_W-1:0] entry;
   logic             wr_en;
   logic [IDX_W-1:0] wr_idx;
   logic [ENT_W-1:0] wr_data;
   res_type          res;
   logic [ENT_W-1:0] new_entry;

   assign req_idx = req_pc[IDX_W-1:0];
   assign req_tag = req_pc[63:IDX_W];

   assign complete  = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = clear_ff || (s1_valid_ff && !complete);
   assign accept    = req_valid && !req_stall;

   assign rd_idx = accept ? req_idx : s1_idx_ff;
   assign entry  = byp_ff ? byp_data_ff : rd_data;

   always_comb begin
      if (clear_ff) begin
         wr_en   = 1'b1;
         wr_idx  = clr_idx_ff;
         wr_data = '0;
      end else begin
         wr_en   = complete && res.write;
         wr_idx  = s1_idx_ff;
         wr_data = new_entry;
      end
   end

   btb_table #(
      .ENTRIES (ENTRIES),
      .WIDTH   (ENT_W)
   ) u_table (
      .clock   (clock),
      .rd_idx  (rd_idx),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_idx  (wr_idx),
      .wr_data (wr_data)
   );

   btb_eval #(
      .TAG_W (TAG_W)
   ) u_eval (
      .entry             (entry),
      .is_branch         (s1_branch_ff),
      .is_conditional    (s1_cond_ff),
      .taken             (s1_taken_ff),
      .tag               (s1_tag_ff),
      .mispredict_cycles (mispredict_cycles_ff),
      .btb_miss_cycles   (btb_miss_cycles_ff),
      .res               (res),
      .new_entry         (new_entry)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (complete) begin
         rsp_valid_in = 1'b1;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         mispredict_cycles_ff <= MISPREDICT_CYCLES_RST;
         btb_miss_cycles_ff   <= BTB_MISS_CYCLES_RST;
         clear_ff             <= 1'b1;
         clr_idx_ff           <= '0;
         s1_valid_ff          <= 1'b0;
         byp_ff               <= 1'b0;
         rsp_valid_ff         <= 1'b0;
         cycle_count_ff       <= '0;
         hit_count_ff         <= '0;
         miss_count_ff        <= '0;
         mispredict_count_ff  <= '0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_MISPREDICT_CYCLES: mispredict_cycles_ff <= csr_wdata;
               CSR_BTB_MISS_CYCLES:   btb_miss_cycles_ff   <= csr_wdata;
               default: ;
            endcase
         end
         if (clear_ff) begin
            clr_idx_ff <= clr_idx_ff + IDX_W'(1);
            if (clr_idx_ff == IDX_W'(ENTRIES - 1)) begin
               clear_ff <= 1'b0;
            end
         end
         s1_valid_ff  <= accept || (s1_valid_ff && !complete);
         byp_ff       <= accept && complete && res.write && (req_idx == s1_idx_ff);
         rsp_valid_ff <= rsp_valid_in;
         if (complete) begin
            cycle_count_ff <= sat_add32(cycle_count_ff, {28'd0, res.cycles});
            if (res.hit) begin
               hit_count_ff <= sat_add32(hit_count_ff, 32'd1);
            end
            if (res.miss) begin
               miss_count_ff <= sat_add32(miss_count_ff, 32'd1);
            end
            if (res.mispredict) begin
               mispredict_count_ff <= sat_add32(mispredict_count_ff, 32'd1);
            end
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_branch_ff <= req_is_branch;
         s1_cond_ff   <= req_is_conditional;
         s1_taken_ff  <= (req_pc + {60'd0, req_inst_size}) != req_next_address;
         s1_idx_ff    <= req_idx;
         s1_tag_ff    <= req_tag;
      end
      if (complete) begin
         byp_data_ff    <= new_entry;
         rsp_outcome_ff <= res.outcome;
         rsp_cycles_ff  <= res.cycles;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_outcome          = rsp_outcome_ff;
   assign rsp_cycles_added     = rsp_cycles_ff;
   assign rsp_cycle_total      = cycle_count_ff;
   assign rsp_hit_total        = hit_count_ff;
   assign rsp_miss_total       = miss_count_ff;
   assign rsp_mispredict_total = mispredict_count_ff;

endmodule

// ===== test/tb_btb_two_bit_branch_predictor.sv =====
// testbench of the branch target buffer predictor: random and directed items against a scoreboard

localparam int TABLE_DEPTH = btb_pkg::ENTRIES_DEF;

typedef struct {
   logic        is_branch;
   logic [63:0] pc;
   logic [3:0]  size;
   logic        conditional;
   logic [63:0] next_pc;
} instr_type;

typedef struct {
   logic [2:0]  outcome;
   logic [3:0]  cycles;
   logic [31:0] cycle_sum;
   logic [31:0] hit_sum;
   logic [31:0] miss_sum;
   logic [31:0] mispredict_sum;
} result_type;

class prediction_board_type;
   bit [3:0]   mispredict_cost;
   bit [3:0]   miss_cost;
   bit         entry_valid [TABLE_DEPTH];
   bit [63:0]  entry_tag [TABLE_DEPTH];
   bit         entry_cond [TABLE_DEPTH];
   bit [1:0]   entry_ctr [TABLE_DEPTH];
   bit [31:0]  cycle_sum;
   bit [31:0]  hit_sum;
   bit [31:0]  miss_sum;
   bit [31:0]  mispredict_sum;
   result_type expected_results [$];
   int         mismatches;

   function new();
      mispredict_cost = btb_pkg::MISPREDICT_CYCLES_RST;
      miss_cost       = btb_pkg::BTB_MISS_CYCLES_RST;
   endfunction

   function bit [31:0] add_sat(bit [31:0] a, bit [31:0] b);
      bit [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

   function void set_cost(logic [btb_pkg::CSR_IDX_W-1:0] idx, bit [3:0] value);
      if (idx == btb_pkg::CSR_MISPREDICT_CYCLES)
         mispredict_cost = value;
      else if (idx == btb_pkg::CSR_BTB_MISS_CYCLES)
         miss_cost = value;
   endfunction

   function int pending();
      return expected_results.size();
   endfunction

   function void note_instr(instr_type it);
      int         idx;
      bit [63:0]  tag;
      bit         taken;
      bit         guess_taken;
      result_type r;
      idx = int'(it.pc % TABLE_DEPTH);
      tag = it.pc / TABLE_DEPTH;
      r.outcome = btb_pkg::OUT_NOT_BRANCH;
      r.cycles  = 4'd1;
      if (it.is_branch) begin
         if (entry_valid[idx] && entry_tag[idx] == tag) begin
            hit_sum = add_sat(hit_sum, 32'd1);
            if (!entry_cond[idx]) begin
               r.outcome = btb_pkg::OUT_UNCOND_HIT;
            end else begin
               taken       = (it.pc + 64'(it.size)) != it.next_pc;
               guess_taken = entry_ctr[idx][1];
               if (taken == guess_taken) begin
                  r.outcome = btb_pkg::OUT_PREDICT_OK;
               end else begin
                  r.outcome      = btb_pkg::OUT_MISPREDICT;
                  r.cycles       = mispredict_cost;
                  mispredict_sum = add_sat(mispredict_sum, 32'd1);
               end
               if (taken && entry_ctr[idx] != 2'd3)
                  entry_ctr[idx]++;
               else if (!taken && entry_ctr[idx] != 2'd0)
                  entry_ctr[idx]--;
            end
         end else begin
            r.outcome        = btb_pkg::OUT_BTB_MISS;
            r.cycles         = miss_cost;
            miss_sum         = add_sat(miss_sum, 32'd1);
            entry_valid[idx] = 1'b1;
            entry_tag[idx]   = tag;
            entry_cond[idx]  = it.conditional;
            entry_ctr[idx]   = 2'd0;
         end
      end
      cycle_sum        = add_sat(cycle_sum, 32'(r.cycles));
      r.cycle_sum      = cycle_sum;
      r.hit_sum        = hit_sum;
      r.miss_sum       = miss_sum;
      r.mispredict_sum = mispredict_sum;
      expected_results.push_back(r);
   endfunction

   function void check_result(result_type got);
      result_type exp;
      if (expected_results.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("unexpected result: outcome %0d cycles %0d", got.outcome, got.cycles);
         return;
      end
      exp = expected_results.pop_front();
      if (got.outcome !== exp.outcome || got.cycles !== exp.cycles
          || got.cycle_sum !== exp.cycle_sum || got.hit_sum !== exp.hit_sum
          || got.miss_sum !== exp.miss_sum || got.mispredict_sum !== exp.mispredict_sum) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("mismatch: expected outcome %0d cycles %0d totals %0d %0d %0d %0d",
                     exp.outcome, exp.cycles, exp.cycle_sum, exp.hit_sum, exp.miss_sum,
                     exp.mispredict_sum);
            $display("          got      outcome %0d cycles %0d totals %0d %0d %0d %0d",
                     got.outcome, got.cycles, got.cycle_sum, got.hit_sum, got.miss_sum,
                     got.mispredict_sum);
         end
      end
   endfunction
endclass

module tb_btb_two_bit_branch_predictor;
   timeunit 1ns;
   timeprecision 1ps;
   import btb_pkg::*;

   localparam int CYCLE_LIMIT = 500000;
   localparam int POOL        = 32;
   localparam bit [63:0] P1   = 64'hA5A5_0000_1234_5E7C;
   localparam bit [63:0] P2   = 64'h0000_0000_0000_0A33;
   localparam bit [63:0] P3   = 64'hFFFF_FFFF_FFFF_FE33;
   localparam bit [63:0] PW   = 64'hFFFF_FFFF_FFFF_FFF8;
   localparam bit [63:0] ONES = 64'hFFFF_FFFF_FFFF_FFFF;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic                 req_is_branch = 1'b0;
   logic [63:0]          req_pc = '0;
   logic [3:0]           req_inst_size = '0;
   logic                 req_is_conditional = 1'b0;
   logic [63:0]          req_next_address = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [2:0]           rsp_outcome;
   logic [3:0]           rsp_cycles_added;
   logic [31:0]          rsp_cycle_total;
   logic [31:0]          rsp_hit_total;
   logic [31:0]          rsp_miss_total;
   logic [31:0]          rsp_mispredict_total;
   logic                 csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [3:0]           csr_wdata = '0;

   prediction_board_type board = new();
   int        send_idle_pct = 0;
   int        stall_pct = 0;
   int        hold_left = 0;
   int        cycle_count = 0;
   bit [63:0] pool_pc [POOL];
   int        pool_bias [POOL];
   bit        pool_cond [POOL];

   btb_two_bit_branch_predictor u_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_is_branch        (req_is_branch),
      .req_pc               (req_pc),
      .req_inst_size        (req_inst_size),
      .req_is_conditional   (req_is_conditional),
      .req_next_address     (req_next_address),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_outcome          (rsp_outcome),
      .rsp_cycles_added     (rsp_cycles_added),
      .rsp_cycle_total      (rsp_cycle_total),
      .rsp_hit_total        (rsp_hit_total),
      .rsp_miss_total       (rsp_miss_total),
      .rsp_mispredict_total (rsp_mispredict_total),
      .csr_wr_en            (csr_wr_en),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL btb_two_bit_branch_predictor");
         $finish;
      end
   end

   always @(posedge clock) begin : monitor
      instr_type  seen;
      result_type got;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            seen = '{req_is_branch, req_pc, req_inst_size, req_is_conditional,
                     req_next_address};
            board.note_instr(seen);
         end
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_outcome, rsp_cycles_added, rsp_cycle_total, rsp_hit_total,
                    rsp_miss_total, rsp_mispredict_total};
            board.check_result(got);
         end
      end
   end

   // receiver back-pressure, with an occasional long hold
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   function automatic instr_type make_instr(bit b, bit [63:0] pc, bit [3:0] size, bit cond,
                                            bit [63:0] next_pc);
      instr_type it;
      it = '{b, pc, size, cond, next_pc};
      return it;
   endfunction

   function automatic instr_type random_instr();
      instr_type it;
      int        kind;
      int        p;
      kind           = $urandom_range(99);
      p              = $urandom_range(POOL-1);
      it.is_branch   = 1'b1;
      it.pc          = {$urandom, $urandom};
      it.size        = 4'($urandom_range(15));
      it.conditional = 1'($urandom_range(1));
      it.next_pc     = {$urandom, $urandom};
      if (kind < 12) begin
         it.is_branch = 1'b0;
      end else if (kind < 22) begin
         if ($urandom_range(1))
            it.next_pc = it.pc + 64'(it.size);
      end else begin
         it.pc          = pool_pc[p];
         it.conditional = (kind < 26) ? !pool_cond[p] : pool_cond[p];
         if ($urandom_range(99) >= pool_bias[p])
            it.next_pc = it.pc + 64'(it.size);
      end
      return it;
   endfunction

   task automatic build_pool();
      for (int i = 0; i < POOL; i++) begin
         pool_pc[i] = {$urandom, $urandom};
         // later entries share an index with earlier ones to force conflicts
         if (i >= 20)
            pool_pc[i][8:0] = pool_pc[i-12][8:0];
         pool_bias[i] = $urandom_range(100);
         pool_cond[i] = ($urandom_range(9) != 0);
      end
   endtask

   task automatic send_instr(instr_type it);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid          <= 1'b1;
      req_is_branch      <= it.is_branch;
      req_pc             <= it.pc;
      req_inst_size      <= it.size;
      req_is_conditional <= it.conditional;
      req_next_address   <= it.next_pc;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      @(negedge clock);
   endtask

   task automatic settle(int idle, int stall);
      req_valid <= 1'b0;
      while (board.pending() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
      send_idle_pct = idle;
      stall_pct     = stall;
      @(negedge clock);
   endtask

   task automatic set_costs(bit [3:0] mispredict_cost, bit [3:0] miss_cost);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_MISPREDICT_CYCLES;
      csr_wdata <= mispredict_cost;
      @(posedge clock);
      board.set_cost(CSR_MISPREDICT_CYCLES, mispredict_cost);
      @(negedge clock);
      csr_index <= CSR_BTB_MISS_CYCLES;
      csr_wdata <= miss_cost;
      @(posedge clock);
      board.set_cost(CSR_BTB_MISS_CYCLES, miss_cost);
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic run_phase(bit [3:0] mispredict_cost, bit [3:0] miss_cost, int idle,
                            int stall, int count, bit long_hold);
      settle(idle, stall);
      set_costs(mispredict_cost, miss_cost);
      for (int i = 0; i < count; i++) begin
         if (long_hold && i == count / 2) begin
            req_valid <= 1'b0;
            @(posedge clock);
            hold_left = 300;
            @(negedge clock);
         end
         send_instr(random_instr());
      end
   endtask

   task automatic directed_items();
      send_instr(make_instr(1'b0, 64'd0, 4'd0, 1'b1, ONES));
      send_instr(make_instr(1'b0, ONES, 4'd15, 1'b0, 64'd0));
      // counter walk up to saturation and back down
      send_instr(make_instr(1'b1, P1, 4'd4, 1'b1, P1 + 64'd4));
      repeat (4) send_instr(make_instr(1'b1, P1, 4'd4, 1'b1, P1 + 64'h100));
      repeat (4) send_instr(make_instr(1'b1, P1, 4'd4, 1'b1, P1 + 64'd4));
      // unconditional entry hit with the conditional flag set, then a conflict
      send_instr(make_instr(1'b1, P2, 4'd2, 1'b0, 64'h1234));
      send_instr(make_instr(1'b1, P2, 4'd2, 1'b1, P2 + 64'd2));
      send_instr(make_instr(1'b1, P3, 4'd2, 1'b1, 64'd0));
      send_instr(make_instr(1'b1, P2, 4'd2, 1'b1, 64'd0));
      // fall-through address wrapping past the top
      send_instr(make_instr(1'b1, PW, 4'd15, 1'b1, 64'd7));
      send_instr(make_instr(1'b1, PW, 4'd15, 1'b1, 64'd7));
      send_instr(make_instr(1'b1, PW, 4'd0, 1'b1, PW));
      send_instr(make_instr(1'b1, 64'd0, 4'd15, 1'b1, 64'd0));
      send_instr(make_instr(1'b1, 64'd0, 4'd15, 1'b1, 64'd0));
      send_instr(make_instr(1'b1, ONES, 4'd1, 1'b0, 64'd0));
      send_instr(make_instr(1'b1, ONES, 4'd1, 1'b1, ONES));
   endtask

   initial begin
      build_pool();
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      directed_items();
      run_phase(4'd15, 4'd1, 0, 0, 300, 1'b0);
      run_phase(4'd1, 4'd15, 83, 0, 250, 1'b0);
      run_phase(4'd0, 4'd0, 0, 83, 250, 1'b0);
      run_phase(4'd7, 4'd9, 31, 31, 250, 1'b0);
      run_phase(4'd15, 4'd15, 0, 0, 250, 1'b1);
      settle(0, 0);
      if (board.mismatches == 0 && board.pending() == 0)
         $display("PASS btb_two_bit_branch_predictor");
      else
         $display("FAIL btb_two_bit_branch_predictor");
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/btb_pkg.sv
hw/rtl/btb_table.sv
hw/rtl/btb_eval.sv
hw/rtl/btb_two_bit_branch_predictor.sv
test/tb_btb_two_bit_branch_predictor.sv
